### design/stft_pkg.sv
// Shared types and constants for the sparse triple fast transpose unit.
// No dependencies; used by sparse_triple_fast_transpose_unit, stft_result_checker and the testbench.
package stft_pkg;

  localparam int MAX_NONZERO = 4096;
  localparam int MAX_DIM     = 256;

  localparam int IDX_W     = 9;
  localparam int VAL_W     = 32;
  localparam int NZ_AW     = $clog2(MAX_NONZERO);
  localparam int CNT_W     = $clog2(MAX_NONZERO + 1);
  localparam int DIM_AW    = $clog2(MAX_DIM);
  localparam int K_W       = $clog2(MAX_DIM + 1);
  localparam int AREA_W    = 2 * IDX_W;
  localparam int TRIP_W    = 2 * IDX_W + VAL_W;
  localparam int CFG_IDX_W = 4;

  localparam logic [IDX_W-1:0] DIM_RESET = IDX_W'(256);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_GIVEN  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 4'd0,
    CFG_COL_COUNT = 4'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PFX,
    S_SC0,
    S_SC1,
    S_SC2,
    S_DRRD,
    S_DRAIN
  } fsm_e;

  typedef struct packed {
    action_e                  action;
    logic [IDX_W-1:0]         in_row;
    logic [IDX_W-1:0]         in_col;
    logic signed [VAL_W-1:0]  in_value;
  } in_word_t;

  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [VAL_W-1:0]  out_value;
    logic                     is_last;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } trip_t;

  // one-based column index to histogram slot
  function automatic logic [DIM_AW-1:0] col_slot(input logic [IDX_W-1:0] c);
    logic [IDX_W-1:0] tmp;
    tmp = c - IDX_W'(1);
    return tmp[DIM_AW-1:0];
  endfunction

endpackage

### design/stft_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/sparse_triple_fast_transpose_unit.sv
// Sparse matrix fast transpose: triple load, column histogram, prefix sum and scatter.
// Depends on stft_pkg and stft_ram.
//
//  channel  | handshake                    | word
//  ---------+------------------------------+----------------------------
//  request  | start / busy                 | req_i (in_word_t)
//  result   | res_strobe_o, one cycle      | res_o (out_word_t)
//  config   | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// Load and drain each run a request step (request + one RAM read), then an
// update step; the result shows in the cycle after. The first drain after
// loading adds a prefix sum over the histogram RAM, a scatter of each loaded
// triple (source read, start read, write back) and a turnaround state.
// Reset clears histogram valid bits at once; no clearing pass. Config is
// always ready. The receiver cannot stall results.
module sparse_triple_fast_transpose_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  stft_pkg::in_word_t                 req_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stft_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [stft_pkg::IDX_W-1:0]         cfg_data_i,
  output logic                               res_strobe_o,
  output stft_pkg::out_word_t                res_o
);

  stft_pkg::fsm_e                      state_q, state_d;
  logic [stft_pkg::IDX_W-1:0]          row_cnt_q, col_cnt_q;
  logic [stft_pkg::CNT_W-1:0]          loaded_q, loaded_d;
  logic [stft_pkg::CNT_W-1:0]          dptr_q, dptr_d;
  logic [stft_pkg::CNT_W-1:0]          j_q, j_d;
  logic [stft_pkg::K_W-1:0]            k_q, k_d;
  logic [stft_pkg::CNT_W-1:0]          run_q, run_d;
  logic                                tready_q, tready_d;
  logic                                rej_q, rej_d;
  logic [stft_pkg::MAX_DIM-1:0]        vld_q, vld_d;
  stft_pkg::in_word_t                  req_q, req_d;
  stft_pkg::trip_t                     trip_q, trip_d;
  stft_pkg::out_word_t                 res_q, res_d;
  logic                                strobe_q, strobe_d;

  logic                                src_we;
  stft_pkg::trip_t                     src_wdata, src_rd;
  logic                                trn_we;
  logic [stft_pkg::NZ_AW-1:0]          trn_waddr;
  stft_pkg::trip_t                     trn_wdata, trn_rd;
  logic                                cnt_we;
  logic [stft_pkg::DIM_AW-1:0]         cnt_waddr, cnt_raddr, pfx_slot;
  logic [stft_pkg::CNT_W-1:0]          cnt_wdata, cnt_rd, hist_old;

  logic                                accept;
  logic [stft_pkg::CNT_W-1:0]          base_cnt, next_cnt;
  logic [stft_pkg::AREA_W-1:0]         area;
  logic                                reject;

  assign busy        = (state_q != stft_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign base_cnt = tready_q ? '0 : loaded_q;
  assign next_cnt = base_cnt + stft_pkg::CNT_W'(1);
  assign area     = stft_pkg::AREA_W'(row_cnt_q) * stft_pkg::AREA_W'(col_cnt_q);
  assign reject   = (req_i.in_row == '0) || (req_i.in_row > row_cnt_q) ||
                    (32'(req_i.in_row) > stft_pkg::MAX_DIM) ||
                    (req_i.in_col == '0) || (req_i.in_col > col_cnt_q) ||
                    (32'(req_i.in_col) > stft_pkg::MAX_DIM) ||
                    (stft_pkg::AREA_W'(next_cnt) > area) ||
                    (32'(next_cnt) > stft_pkg::MAX_NONZERO);

  assign pfx_slot = stft_pkg::DIM_AW'(k_q - stft_pkg::K_W'(1));
  assign hist_old = vld_q[stft_pkg::col_slot(req_q.in_col)] ? cnt_rd : '0;

  stft_ram #(.WIDTH(stft_pkg::TRIP_W), .DEPTH(stft_pkg::MAX_NONZERO)) u_src (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (loaded_q[stft_pkg::NZ_AW-1:0]),
    .wdata_i (src_wdata),
    .raddr_i (j_q[stft_pkg::NZ_AW-1:0]),
    .rdata_o (src_rd)
  );

  stft_ram #(.WIDTH(stft_pkg::TRIP_W), .DEPTH(stft_pkg::MAX_NONZERO)) u_trn (
    .clk_i   (clk_i),
    .we_i    (trn_we),
    .waddr_i (trn_waddr),
    .wdata_i (trn_wdata),
    .raddr_i (dptr_q[stft_pkg::NZ_AW-1:0]),
    .rdata_o (trn_rd)
  );

  // histogram, overwritten in place by column start positions
  stft_ram #(.WIDTH(stft_pkg::CNT_W), .DEPTH(stft_pkg::MAX_DIM)) u_cnt (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    dptr_d   = dptr_q;
    j_d      = j_q;
    k_d      = k_q;
    run_d    = run_q;
    tready_d = tready_q;
    rej_d    = rej_q;
    vld_d    = vld_q;
    req_d    = req_q;
    trip_d   = trip_q;
    res_d    = res_q;
    strobe_d = 1'b0;

    src_we    = 1'b0;
    src_wdata = '{row: req_q.in_row, col: req_q.in_col, value: req_q.in_value};
    trn_we    = 1'b0;
    trn_waddr = cnt_rd[stft_pkg::NZ_AW-1:0];
    trn_wdata = '{row: trip_q.col, col: trip_q.row, value: trip_q.value};
    cnt_we    = 1'b0;
    cnt_waddr = stft_pkg::col_slot(req_q.in_col);
    cnt_wdata = hist_old + stft_pkg::CNT_W'(1);
    cnt_raddr = stft_pkg::col_slot(trip_q.col);

    case (state_q)
      stft_pkg::S_IDLE: begin
        cnt_raddr = stft_pkg::col_slot(req_i.in_col);
        if (accept) begin
          req_d = req_i;
          if (req_i.action == stft_pkg::ACT_LOAD) begin
            if (tready_q) begin
              vld_d    = '0;
              loaded_d = '0;
              dptr_d   = '0;
              tready_d = 1'b0;
            end
            rej_d   = reject;
            state_d = stft_pkg::S_LOAD;
          end else if (tready_q) begin
            state_d = stft_pkg::S_DRAIN;
          end else begin
            k_d     = '0;
            run_d   = '0;
            dptr_d  = '0;
            state_d = stft_pkg::S_PFX;
          end
        end
      end
      stft_pkg::S_LOAD: begin
        strobe_d = 1'b1;
        res_d    = '0;
        if (rej_q) begin
          res_d.status = stft_pkg::ST_REJECT;
        end else begin
          res_d.status = stft_pkg::ST_LOADED;
          src_we   = 1'b1;
          cnt_we   = 1'b1;
          vld_d[stft_pkg::col_slot(req_q.in_col)] = 1'b1;
          loaded_d = loaded_q + stft_pkg::CNT_W'(1);
        end
        state_d = stft_pkg::S_IDLE;
      end
      stft_pkg::S_PFX: begin
        cnt_raddr = k_q[stft_pkg::DIM_AW-1:0];
        if (k_q != '0) begin
          cnt_we          = 1'b1;
          cnt_waddr       = pfx_slot;
          cnt_wdata       = run_q;
          run_d           = run_q + (vld_q[pfx_slot] ? cnt_rd : '0);
          vld_d[pfx_slot] = 1'b1;
        end
        if (k_q == stft_pkg::K_W'(stft_pkg::MAX_DIM)) begin
          j_d     = '0;
          state_d = stft_pkg::S_SC0;
        end else begin
          k_d = k_q + stft_pkg::K_W'(1);
        end
      end
      stft_pkg::S_SC0: begin
        if (j_q == loaded_q) begin
          tready_d = 1'b1;
          state_d  = stft_pkg::S_DRRD;
        end else begin
          state_d = stft_pkg::S_SC1;
        end
      end
      stft_pkg::S_SC1: begin
        trip_d    = src_rd;
        cnt_raddr = stft_pkg::col_slot(src_rd.col);
        state_d   = stft_pkg::S_SC2;
      end
      stft_pkg::S_SC2: begin
        trn_we    = 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = stft_pkg::col_slot(trip_q.col);
        cnt_wdata = cnt_rd + stft_pkg::CNT_W'(1);
        j_d       = j_q + stft_pkg::CNT_W'(1);
        state_d   = stft_pkg::S_SC0;
      end
      stft_pkg::S_DRRD: begin
        state_d = stft_pkg::S_DRAIN;
      end
      stft_pkg::S_DRAIN: begin
        strobe_d = 1'b1;
        res_d    = '0;
        if (dptr_q < loaded_q) begin
          res_d.status    = stft_pkg::ST_GIVEN;
          res_d.out_row   = trn_rd.row;
          res_d.out_col   = trn_rd.col;
          res_d.out_value = signed'(trn_rd.value);
          res_d.is_last   = (dptr_q + stft_pkg::CNT_W'(1) == loaded_q);
          dptr_d          = dptr_q + stft_pkg::CNT_W'(1);
        end else begin
          res_d.status = stft_pkg::ST_EMPTY;
        end
        state_d = stft_pkg::S_IDLE;
      end
      default: begin
        state_d = stft_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stft_pkg::S_IDLE;
      row_cnt_q <= stft_pkg::DIM_RESET;
      col_cnt_q <= stft_pkg::DIM_RESET;
      loaded_q  <= '0;
      dptr_q    <= '0;
      j_q       <= '0;
      k_q       <= '0;
      run_q     <= '0;
      tready_q  <= 1'b0;
      rej_q     <= 1'b0;
      vld_q     <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      dptr_q   <= dptr_d;
      j_q      <= j_d;
      k_q      <= k_d;
      run_q    <= run_d;
      tready_q <= tready_d;
      rej_q    <= rej_d;
      vld_q    <= vld_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == stft_pkg::CFG_ROW_COUNT) begin
          row_cnt_q <= cfg_data_i;
        end else if (cfg_index_i == stft_pkg::CFG_COL_COUNT) begin
          col_cnt_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    trip_q <= trip_d;
    res_q  <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> ($past(state_q) == stft_pkg::S_LOAD ||
                      $past(state_q) == stft_pkg::S_DRAIN))
    else $error("result strobe without load or drain step");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(loaded_q) <= stft_pkg::MAX_NONZERO)
    else $error("loaded count past store depth");

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tready_q |-> dptr_q <= loaded_q)
    else $error("drain pointer past loaded count");

endmodule

### test/stft_result_checker.sv
// Result checker for sparse_triple_fast_transpose_unit: watches the request, config and
// result channels, predicts each result word and compares it field by field.
// Depends on stft_pkg.
module stft_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  stft_pkg::in_word_t             req_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [stft_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [stft_pkg::IDX_W-1:0]     cfg_data_i,
  input  logic                           res_strobe_i,
  input  stft_pkg::out_word_t            res_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [stft_pkg::IDX_W-1:0] rows_lim;
  logic [stft_pkg::IDX_W-1:0] cols_lim;
  stft_pkg::trip_t            src_mem   [stft_pkg::MAX_NONZERO];
  stft_pkg::trip_t            xpose_mem [stft_pkg::MAX_NONZERO];
  int unsigned                col_hist  [stft_pkg::MAX_DIM];
  int unsigned                held_cnt;
  int unsigned                drain_ptr;
  bit                         xpose_built;
  stft_pkg::out_word_t        expected_q [$];
  int                         fails;
  int                         checked;

  function automatic stft_pkg::out_word_t predict_word(stft_pkg::in_word_t w);
    stft_pkg::out_word_t r;
    int unsigned         nxt;
    int unsigned         k;
    int unsigned         slot;
    int unsigned         run;
    int unsigned         col_next [stft_pkg::MAX_DIM];
    r = '0;
    if (w.action == stft_pkg::ACT_LOAD) begin
      // any load after a drain opens a new matrix
      if (xpose_built) begin
        foreach (col_hist[i]) col_hist[i] = 0;
        held_cnt    = 0;
        drain_ptr   = 0;
        xpose_built = 1'b0;
      end
      nxt = held_cnt + 1;
      if (w.in_row == '0 || w.in_row > rows_lim || w.in_row > stft_pkg::MAX_DIM ||
          w.in_col == '0 || w.in_col > cols_lim || w.in_col > stft_pkg::MAX_DIM ||
          nxt > int'(rows_lim) * int'(cols_lim) || nxt > stft_pkg::MAX_NONZERO) begin
        r.status = stft_pkg::ST_REJECT;
      end else begin
        src_mem[held_cnt] = '{row: w.in_row, col: w.in_col, value: w.in_value};
        col_hist[w.in_col - 1]++;
        held_cnt = nxt;
        r.status = stft_pkg::ST_LOADED;
      end
      return r;
    end
    if (!xpose_built) begin
      run = 0;
      for (k = 0; k < stft_pkg::MAX_DIM; k++) begin
        col_next[k] = run;
        run += col_hist[k];
      end
      for (k = 0; k < held_cnt; k++) begin
        slot = col_next[src_mem[k].col - 1];
        col_next[src_mem[k].col - 1] = slot + 1;
        xpose_mem[slot] = '{row: src_mem[k].col, col: src_mem[k].row,
                            value: src_mem[k].value};
      end
      drain_ptr   = 0;
      xpose_built = 1'b1;
    end
    if (drain_ptr < held_cnt) begin
      r.status    = stft_pkg::ST_GIVEN;
      r.out_row   = xpose_mem[drain_ptr].row;
      r.out_col   = xpose_mem[drain_ptr].col;
      r.out_value = xpose_mem[drain_ptr].value;
      r.is_last   = (drain_ptr + 1 == held_cnt);
      drain_ptr++;
    end else begin
      r.status = stft_pkg::ST_EMPTY;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stft_pkg::out_word_t want;
    bit                  bad;
    if (!rst_ni) begin
      rows_lim = stft_pkg::DIM_RESET;
      cols_lim = stft_pkg::DIM_RESET;
      foreach (col_hist[i]) col_hist[i] = 0;
      held_cnt    = 0;
      drain_ptr   = 0;
      xpose_built = 1'b0;
      expected_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          stft_pkg::CFG_ROW_COUNT: rows_lim = cfg_data_i;
          stft_pkg::CFG_COL_COUNT: cols_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_q.push_back(predict_word(req_i));
      if (res_strobe_i) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("%0t: result word with nothing expected", $realtime);
          fails++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          bad = (res_i.status !== want.status) || (res_i.out_row !== want.out_row) ||
                (res_i.out_col !== want.out_col) || (res_i.out_value !== want.out_value) ||
                (res_i.is_last !== want.is_last);
          if (bad) begin
            // fields in order status/row/col/value/last
            if (fails < 10)
              $display("%0t: mismatch exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                       $realtime, want.status, want.out_row, want.out_col, want.out_value,
                       want.is_last, res_i.status, res_i.out_row, res_i.out_col,
                       res_i.out_value, res_i.is_last);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
  end

endmodule

### test/sparse_triple_fast_transpose_unit_tb.sv
// Testbench top for sparse_triple_fast_transpose_unit: drives load/drain and config words
// with random gaps and gives the verdict. Depends on stft_pkg, the unit and
// stft_result_checker.
module sparse_triple_fast_transpose_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [stft_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           start     = 1'b0;
  logic                           busy;
  stft_pkg::in_word_t             req       = '0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [stft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [stft_pkg::IDX_W-1:0]     cfg_data  = '0;
  logic                           res_strobe;
  stft_pkg::out_word_t            res;

  int fail_count;
  int pending;
  int checked;
  int loads_sent  = 0;
  int drains_sent = 0;
  int cfg_writes  = 0;
  int rows_set    = 256;
  int cols_set    = 256;
  bit gaps_on     = 1'b1;

  sparse_triple_fast_transpose_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .res_strobe_o(res_strobe),
    .res_o       (res)
  );

  stft_result_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .res_strobe_i(res_strobe),
    .res_i       (res),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [stft_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(stft_pkg::action_e act, int row, int col,
                      logic [stft_pkg::VAL_W-1:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{action: act, in_row: stft_pkg::IDX_W'(row), in_col: stft_pkg::IDX_W'(col),
               in_value: val};
    do @(posedge clk); while (busy);
    if (act == stft_pkg::ACT_LOAD) loads_sent++;
    else drains_sent++;
  endtask

  task automatic drain_n(int n);
    repeat (n) send(stft_pkg::ACT_DRAIN, $urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom());
  endtask

  // hold off until every predicted word has come back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [stft_pkg::CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= stft_pkg::IDX_W'(data);
    do @(posedge clk); while (!cfg_ready);
    if (idx == stft_pkg::CFG_ROW_COUNT) rows_set = data & 'h1FF;
    else if (idx == stft_pkg::CFG_COL_COUNT) cols_set = data & 'h1FF;
    cfg_writes++;
  endtask

  task automatic set_dims(int rows, int cols);
    if ($urandom_range(0, 1)) begin
      write_reg(stft_pkg::CFG_ROW_COUNT, rows);
      write_reg(stft_pkg::CFG_COL_COUNT, cols);
    end else begin
      write_reg(stft_pkg::CFG_COL_COUNT, cols);
      write_reg(stft_pkg::CFG_ROW_COUNT, rows);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_matrix();
    int n;
    int lim_r;
    int lim_c;
    int n_drain;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    lim_r = (rows_set > stft_pkg::MAX_DIM) ? stft_pkg::MAX_DIM : rows_set;
    lim_c = (cols_set > stft_pkg::MAX_DIM) ? stft_pkg::MAX_DIM : cols_set;
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat (n) begin
      if (lim_r == 0 || lim_c == 0 || $urandom_range(0, 9) == 0)
        send(stft_pkg::ACT_LOAD, $urandom_range(0, 511), $urandom_range(0, 511),
             pick_value());
      else
        send(stft_pkg::ACT_LOAD, $urandom_range(1, lim_r), $urandom_range(1, lim_c),
             pick_value());
      if ($urandom_range(0, 39) == 0) drain_n(1);
    end
    n_drain = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 3);
    drain_n(n_drain);
  endtask

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty drain, index extremes, bad indexes, drain past the end
    drain_n(1);
    send(stft_pkg::ACT_LOAD, 1, 1, 32'h7FFF_FFFF);
    send(stft_pkg::ACT_LOAD, 256, 256, 32'h8000_0000);
    send(stft_pkg::ACT_LOAD, 2, 1, 32'hFFFF_FFFF);
    send(stft_pkg::ACT_LOAD, 0, 5, $urandom());
    send(stft_pkg::ACT_LOAD, 257, 3, $urandom());
    send(stft_pkg::ACT_LOAD, 3, 0, $urandom());
    send(stft_pkg::ACT_LOAD, 511, 511, $urandom());
    drain_n(4);
    send(stft_pkg::ACT_LOAD, 0, 0, 32'h0);
    drain_n(1);
    settle();
    set_dims(1, 1);
    send(stft_pkg::ACT_LOAD, 1, 1, 32'h1234_5678);
    send(stft_pkg::ACT_LOAD, 1, 1, 32'h1);
    drain_n(1);
    settle();
    set_dims(0, 0);
    send(stft_pkg::ACT_LOAD, 1, 1, 32'h5);
    settle();
    set_dims(3, 2);
    send(stft_pkg::ACT_LOAD, 3, 2, 32'hA5A5_A5A5);
    settle();
    set_dims(1, 4);
    send(stft_pkg::ACT_LOAD, 1, 4, 32'h5A5A_5A5A);
    send(stft_pkg::ACT_LOAD, 3, 2, 32'h2);
    drain_n(2);
    settle();
    write_reg(CFG_UNUSED_IDX, 9'h1FF);
    set_dims(511, 300);
    send(stft_pkg::ACT_LOAD, 257, 1, 32'h3);
    send(stft_pkg::ACT_LOAD, 256, 256, 32'h4);
    drain_n(1);

    while (loads_sent + drains_sent < 720) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 9))
          0: set_dims(1, 1);
          1: set_dims(256, 256);
          2: set_dims(1, 256);
          3: set_dims(256, 1);
          4, 5, 6: set_dims($urandom_range(1, 4), $urandom_range(1, 4));
          7: set_dims($urandom_range(1, 256), $urandom_range(1, 256));
          8: set_dims($urandom_range(257, 511), $urandom_range(1, 511));
          default: set_dims($urandom_range(0, 1) ? 0 : $urandom_range(1, 9),
                            $urandom_range(0, 8));
        endcase
      end
      random_matrix();
    end

    // back-to-back tail: a 4 by 4 matrix overfilled, then drained past its end
    settle();
    set_dims(4, 4);
    gaps_on = 1'b0;
    repeat (3) begin
      repeat (17)
        send(stft_pkg::ACT_LOAD, $urandom_range(1, 4), $urandom_range(1, 4), pick_value());
      drain_n(18);
    end

    start <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < 10000);
    repeat (20) @(posedge clk);

    $display("Sent %0d loads and %0d drains with %0d register writes; %0d words checked.",
             loads_sent, drains_sent, cfg_writes, checked);
    $display("Covered bad indexes, area limits, empty drains and a back-to-back tail.");
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sparse_triple_fast_transpose_unit.f
design/stft_pkg.sv
design/stft_ram.sv
design/sparse_triple_fast_transpose_unit.sv
test/stft_result_checker.sv
test/sparse_triple_fast_transpose_unit_tb.sv
